// ----- hdl/qts_pkg.sv -----
// Shared types and constants for the quoted token splitter.
// Used by qts_csr, qts_match and quoted_token_splitter_core; no dependencies.
package qts_pkg;

   // Largest number of bytes a delimiter or quote set can hold.
   localparam int unsigned SET_MAX            = 8;
   localparam int unsigned DELIM_SET_SIZE_DEF = 8;
   localparam int unsigned QUOTE_SET_SIZE_DEF = 8;

   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned COUNT_W    = 4;

   // Register indexes; each register sits at byte address 8*index.
   typedef enum logic [1:0] {
      REG_DELIM_CHARS = 2'd0,
      REG_DELIM_COUNT = 2'd1,
      REG_QUOTE_CHARS = 2'd2,
      REG_QUOTE_COUNT = 2'd3
   } reg_index_type;

   localparam logic [63:0]        DELIM_CHARS_RST = 64'd32;
   localparam logic [COUNT_W-1:0] DELIM_COUNT_RST = 4'd1;
   localparam logic [63:0]        QUOTE_CHARS_RST = 64'd34;
   localparam logic [COUNT_W-1:0] QUOTE_COUNT_RST = 4'd1;

   // Configuration seen by the datapath.
   typedef struct packed {
      logic [63:0]        delim_chars;
      logic [COUNT_W-1:0] delim_count;
      logic [63:0]        quote_chars;
      logic [COUNT_W-1:0] quote_count;
   } cfg_type;

endpackage

// ----- hdl/qts_csr.sv -----
// Configuration register file with an APB-style access port.
// Depends on qts_pkg for register indexes, reset values and cfg_type.
module qts_csr import qts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   reg_index_type index;
   logic          write_en;

   // Low address bits select a byte within the 64-bit register and are ignored.
   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delim_chars <= DELIM_CHARS_RST;
         cfg_ff.delim_count <= DELIM_COUNT_RST;
         cfg_ff.quote_chars <= QUOTE_CHARS_RST;
         cfg_ff.quote_count <= QUOTE_COUNT_RST;
      end else if (write_en) begin
         case (index)
            REG_DELIM_CHARS: cfg_ff.delim_chars <= csr_pwdata;
            REG_DELIM_COUNT: cfg_ff.delim_count <= csr_pwdata[COUNT_W-1:0];
            REG_QUOTE_CHARS: cfg_ff.quote_chars <= csr_pwdata;
            REG_QUOTE_COUNT: cfg_ff.quote_count <= csr_pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_DELIM_CHARS: csr_prdata = cfg_ff.delim_chars;
         REG_DELIM_COUNT: csr_prdata = {{(CSR_DATA_W-COUNT_W){1'b0}}, cfg_ff.delim_count};
         REG_QUOTE_CHARS: csr_prdata = cfg_ff.quote_chars;
         REG_QUOTE_COUNT: csr_prdata = {{(CSR_DATA_W-COUNT_W){1'b0}}, cfg_ff.quote_count};
         default:         csr_prdata = '0;
      endcase
   end

endmodule

// ----- hdl/qts_match.sv -----
// Parallel set membership test of one byte against a packed set of bytes.
// Depends on qts_pkg for the set and count widths.
module qts_match import qts_pkg::*; #(
   parameter int unsigned SET_SIZE = DELIM_SET_SIZE_DEF
) (
   input  logic [8*SET_MAX-1:0] set_chars,
   input  logic [COUNT_W-1:0]   set_count,
   input  logic [7:0]           probe,
   output logic                 hit
);

   // Only entries below both the count and the set size take part.
   always_comb begin
      hit = 1'b0;
      for (int k = 0; k < SET_SIZE; k++) begin
         if ((COUNT_W'(k) < set_count) && (set_chars[8*k +: 8] == probe)) begin
            hit = 1'b1;
         end
      end
   end

endmodule

// ----- hdl/quoted_token_splitter_core.sv -----
// Top level of the quoted token splitter: input register, token state machine,
// result register. Depends on qts_pkg, qts_csr and qts_match.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  req_in_byte, req_string_end
//   rsp      out        rsp_valid / rsp_stall  rsp_out_byte, rsp_byte_valid, rsp_token_end
//   csr      in/out     APB-style, pready high 64-bit registers at byte address 8*index
//
// A word is taken into the input register and handled there; when it advances,
// its result is loaded into the result register, from where it can be taken.
// One word is accepted every cycle while the result side keeps up. The pace
// is set by the single pass through the set compares and the state update.
// Reset clears both valid flags and the token state and loads the register
// defaults. A stalled result register holds its word; a word that gives no
// result still drains past it, so only words with a result wait for it.
module quoted_token_splitter_core import qts_pkg::*; #(
   parameter int unsigned DELIM_SET_SIZE = DELIM_SET_SIZE_DEF,
   parameter int unsigned QUOTE_SET_SIZE = QUOTE_SET_SIZE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // input words
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_in_byte,
   input  logic                  req_string_end,
   // result words
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_byte_valid,
   output logic                  rsp_token_end,
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // Token phases: skipping delimiters, in a plain token, inside a quoted
   // literal, and after the literal has closed.
   typedef enum logic [1:0] {
      PH_SKIP    = 2'd0,
      PH_TOKEN   = 2'd1,
      PH_LITERAL = 2'd2,
      PH_AFTER   = 2'd3
   } phase_type;

   cfg_type   cfg;

   // Input register.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   // Token state.
   phase_type  phase_ff, phase_in;
   logic [7:0] open_quote_ff, open_quote_in;

   // Result register and the next result computed from the input register.
   logic       rsp_valid_ff;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       byte_valid_ff, byte_valid_in;
   logic       token_end_ff, token_end_in;
   logic       produce;

   logic       is_delim, is_quote;
   logic       advance, req_take;

   qts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   qts_match #(.SET_SIZE(DELIM_SET_SIZE)) u_delim_match (
      .set_chars (cfg.delim_chars),
      .set_count (cfg.delim_count),
      .probe     (in_byte_ff),
      .hit       (is_delim)
   );

   qts_match #(.SET_SIZE(QUOTE_SET_SIZE)) u_quote_match (
      .set_chars (cfg.quote_chars),
      .set_count (cfg.quote_count),
      .probe     (in_byte_ff),
      .hit       (is_quote)
   );

   // Next state and result for the word in the input register. A token end
   // always returns the machine to skipping with no open quote. Inside a
   // literal only the opening quote byte matters; delimiters pass through.
   always_comb begin
      phase_in      = phase_ff;
      open_quote_in = open_quote_ff;
      produce       = 1'b0;
      out_byte_in   = 8'd0;
      byte_valid_in = 1'b0;
      token_end_in  = 1'b0;

      if (in_end_ff) begin
         if (phase_ff != PH_SKIP) begin
            produce      = 1'b1;
            token_end_in = 1'b1;
         end
         phase_in      = PH_SKIP;
         open_quote_in = 8'd0;
      end else begin
         case (phase_ff)
            PH_LITERAL: begin
               if (in_byte_ff == open_quote_ff) begin
                  phase_in = PH_AFTER;
               end else begin
                  produce       = 1'b1;
                  byte_valid_in = 1'b1;
                  out_byte_in   = in_byte_ff;
               end
            end
            PH_AFTER: begin
               if (is_delim) begin
                  produce       = 1'b1;
                  token_end_in  = 1'b1;
                  phase_in      = PH_SKIP;
                  open_quote_in = 8'd0;
               end else begin
                  produce       = 1'b1;
                  byte_valid_in = 1'b1;
                  out_byte_in   = in_byte_ff;
               end
            end
            default: begin
               // Skipping or in a plain token; a delimiter wins over a quote.
               if (is_delim) begin
                  if (phase_ff == PH_TOKEN) begin
                     produce       = 1'b1;
                     token_end_in  = 1'b1;
                     phase_in      = PH_SKIP;
                     open_quote_in = 8'd0;
                  end
               end else if (is_quote) begin
                  open_quote_in = in_byte_ff;
                  phase_in      = PH_LITERAL;
               end else begin
                  produce       = 1'b1;
                  byte_valid_in = 1'b1;
                  out_byte_in   = in_byte_ff;
                  phase_in      = PH_TOKEN;
               end
            end
         endcase
      end
   end

   // The input word moves on when it gives no result or the result register
   // is free or being emptied this cycle.
   assign advance   = in_valid_ff && (!produce || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= PH_SKIP;
         open_quote_ff <= 8'd0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
            in_byte_ff  <= req_in_byte;
            in_end_ff   <= req_string_end;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            phase_ff      <= phase_in;
            open_quote_ff <= open_quote_in;
         end

         if (advance && produce) begin
            rsp_valid_ff  <= 1'b1;
            out_byte_ff   <= out_byte_in;
            byte_valid_ff <= byte_valid_in;
            token_end_ff  <= token_end_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_token_end  = token_end_ff;

endmodule
